// ===== rtl/min_separation_point_filter_unit_defines.svh =====
// assertion helpers for the point filter
`ifndef MIN_SEPARATION_POINT_FILTER_UNIT_DEFINES_SVH
`define MIN_SEPARATION_POINT_FILTER_UNIT_DEFINES_SVH

// property checked on every clock edge outside reset
`define MSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be seen outside reset
`define MSP_ASSERT_NEVER(label, cond, msg) \
  `MSP_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/msp_pkg.sv =====
package msp_pkg;

  // field widths
  localparam int unsigned CoordW  = 16;
  localparam int unsigned SepW    = 12;
  localparam int unsigned Sep2W   = 2 * SepW;
  localparam int unsigned SqW     = 2 * CoordW;
  localparam int unsigned SumW    = SqW + 2;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 2;

  // separation after reset, 3 units
  localparam logic [SepW-1:0] SepReset = 12'd48;

  // result status codes
  localparam logic [StatusW-1:0] StatusKept  = 2'd0;
  localparam logic [StatusW-1:0] StatusClose = 2'd1;
  localparam logic [StatusW-1:0] StatusFull  = 2'd2;

  // one 3d point
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  // sequencer to distance unit
  typedef struct packed {
    logic clear;
    logic issue;
  } dist_ctl_t;

  // distance unit to sequencer
  typedef struct packed {
    logic busy;
    logic close;
  } dist_sts_t;

  // sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } fsm_e;

endpackage

// ===== rtl/msp_store.sv =====
module msp_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  msp_pkg::point_t     wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output msp_pkg::point_t     rdata_o
);

  msp_pkg::point_t mem_q [Depth];
  msp_pkg::point_t rdata_q;

  // kept point table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/msp_dist.sv =====
module msp_dist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  msp_pkg::dist_ctl_t            ctl_i,
  input  msp_pkg::point_t               kept_i,
  input  msp_pkg::point_t               cand_i,
  input  logic [msp_pkg::Sep2W-1:0]     sep2_i,
  output msp_pkg::dist_sts_t            sts_o
);

  localparam int unsigned DiffW = msp_pkg::CoordW + 1;

  logic                           rd_v_q, sq_v_q, sum_v_q;
  logic                           close_q;
  logic signed [DiffW-1:0]        dx, dy, dz;
  logic [msp_pkg::CoordW-1:0]     mx, my, mz;
  logic [msp_pkg::SqW-1:0]        sqx_d, sqy_d, sqz_d;
  logic [msp_pkg::SqW-1:0]        sqx_q, sqy_q, sqz_q;
  logic [msp_pkg::SumW-1:0]       sum_d, sum_q;

  // per axis difference and magnitude, fits 16 bits unsigned
  assign dx = $signed({kept_i.x[msp_pkg::CoordW-1], kept_i.x})
            - $signed({cand_i.x[msp_pkg::CoordW-1], cand_i.x});
  assign dy = $signed({kept_i.y[msp_pkg::CoordW-1], kept_i.y})
            - $signed({cand_i.y[msp_pkg::CoordW-1], cand_i.y});
  assign dz = $signed({kept_i.z[msp_pkg::CoordW-1], kept_i.z})
            - $signed({cand_i.z[msp_pkg::CoordW-1], cand_i.z});

  assign mx = dx[DiffW-1] ? msp_pkg::CoordW'(-dx) : dx[msp_pkg::CoordW-1:0];
  assign my = dy[DiffW-1] ? msp_pkg::CoordW'(-dy) : dy[msp_pkg::CoordW-1:0];
  assign mz = dz[DiffW-1] ? msp_pkg::CoordW'(-dz) : dz[msp_pkg::CoordW-1:0];

  // squares, one multiplier per axis
  assign sqx_d = msp_pkg::SqW'(mx) * msp_pkg::SqW'(mx);
  assign sqy_d = msp_pkg::SqW'(my) * msp_pkg::SqW'(my);
  assign sqz_d = msp_pkg::SqW'(mz) * msp_pkg::SqW'(mz);

  assign sum_d = msp_pkg::SumW'(sqx_q) + msp_pkg::SumW'(sqy_q) + msp_pkg::SumW'(sqz_q);

  // stage valid flags and sticky too-close flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      sq_v_q  <= 1'b0;
      sum_v_q <= 1'b0;
      close_q <= 1'b0;
    end else begin
      rd_v_q  <= ctl_i.issue & ~ctl_i.clear;
      sq_v_q  <= rd_v_q & ~ctl_i.clear;
      sum_v_q <= sq_v_q & ~ctl_i.clear;
      if (ctl_i.clear) begin
        close_q <= 1'b0;
      end else if (sum_v_q && (sum_q < msp_pkg::SumW'(sep2_i))) begin
        close_q <= 1'b1;
      end
    end
  end

  // datapath stage registers
  always_ff @(posedge clk_i) begin
    sqx_q <= sqx_d;
    sqy_q <= sqy_d;
    sqz_q <= sqz_d;
    sum_q <= sum_d;
  end

  assign sts_o.busy  = rd_v_q | sq_v_q | sum_v_q;
  assign sts_o.close = close_q;

endmodule

// ===== rtl/min_separation_point_filter_unit.sv =====
// Minimum separation point filter. Each candidate point taken on start is
// compared against every point already kept, one table entry per cycle
// through a single read port and a four stage distance pipeline (read,
// square, sum, compare), then appended if no kept point lies closer than
// min_separation and the table is not full. busy stays high while the
// table is scanned, the pipeline drains and the decision is taken. The
// result is shown for one cycle on done_o, in the first cycle with busy
// low; the receiver cannot stall it and must capture it then. A new item
// may be started in that same cycle. min_separation may only be written
// while busy is low.
`include "min_separation_point_filter_unit_defines.svh"

module min_separation_point_filter_unit #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [msp_pkg::SepW-1:0]           cfg_wdata_i,
  input  logic                               start,
  output logic                               busy,
  input  logic                               start_new_set_i,
  input  logic signed [msp_pkg::CoordW-1:0]  pos_x_i,
  input  logic signed [msp_pkg::CoordW-1:0]  pos_y_i,
  input  logic signed [msp_pkg::CoordW-1:0]  pos_z_i,
  input  logic [msp_pkg::KindW-1:0]          seed_kind_i,
  output logic                               done_o,
  output logic [msp_pkg::StatusW-1:0]        status_o,
  output logic [msp_pkg::SlotW-1:0]          slot_o,
  output logic signed [msp_pkg::CoordW-1:0]  out_x_o,
  output logic signed [msp_pkg::CoordW-1:0]  out_y_o,
  output logic signed [msp_pkg::CoordW-1:0]  out_z_o,
  output logic [msp_pkg::KindW-1:0]          out_kind_o
);

  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  msp_pkg::fsm_e                  fsm_q, fsm_d;
  logic [msp_pkg::SepW-1:0]       min_sep_q;
  logic [msp_pkg::Sep2W-1:0]      sep2_q;
  logic [CntW-1:0]                cnt_q, idx_q;
  msp_pkg::point_t                cand_q;
  logic [msp_pkg::KindW-1:0]      kind_q;
  logic                           accept, issue, full, keep, finish;
  logic [CntW+msp_pkg::SlotW-1:0] cnt_ext;
  msp_pkg::point_t                kept_rd;
  msp_pkg::dist_ctl_t             dist_ctl;
  msp_pkg::dist_sts_t             dist_sts;

  logic                           done_q;
  logic [msp_pkg::StatusW-1:0]    status_q;
  logic [msp_pkg::SlotW-1:0]      slot_q;
  msp_pkg::point_t                out_pt_q;
  logic [msp_pkg::KindW-1:0]      out_kind_q;

  assign accept  = start & (fsm_q == msp_pkg::StIdle);
  assign finish  = (fsm_q == msp_pkg::StFinish);
  assign full    = (cnt_q == CntW'(MAX_POINTS));
  assign keep    = ~dist_sts.close & ~full;
  assign cnt_ext = {{msp_pkg::SlotW{1'b0}}, cnt_q};

  // sequencer: scan kept entries, drain the pipeline, then decide
  always_comb begin
    fsm_d = fsm_q;
    issue = 1'b0;
    unique case (fsm_q)
      msp_pkg::StIdle: begin
        if (start) fsm_d = msp_pkg::StScan;
      end
      msp_pkg::StScan: begin
        if (idx_q != cnt_q) begin
          issue = 1'b1;
        end else if (!dist_sts.busy) begin
          fsm_d = msp_pkg::StFinish;
        end
      end
      msp_pkg::StFinish: begin
        fsm_d = msp_pkg::StIdle;
      end
      default: begin
        fsm_d = msp_pkg::StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q     <= msp_pkg::StIdle;
      min_sep_q <= msp_pkg::SepReset;
      cnt_q     <= '0;
      idx_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      fsm_q  <= fsm_d;
      done_q <= finish;
      if (cfg_we_i) begin
        min_sep_q <= cfg_wdata_i;
      end
      if (accept) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (accept && start_new_set_i) begin
        cnt_q <= '0;
      end else if (finish && keep) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // item capture and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cand_q.x <= pos_x_i;
      cand_q.y <= pos_y_i;
      cand_q.z <= pos_z_i;
      kind_q   <= seed_kind_i;
      sep2_q   <= msp_pkg::Sep2W'(min_sep_q) * msp_pkg::Sep2W'(min_sep_q);
    end
    if (finish) begin
      if (dist_sts.close) begin
        status_q <= msp_pkg::StatusClose;
      end else if (full) begin
        status_q <= msp_pkg::StatusFull;
      end else begin
        status_q <= msp_pkg::StatusKept;
      end
      slot_q     <= keep ? cnt_ext[msp_pkg::SlotW-1:0] : '0;
      out_pt_q   <= cand_q;
      out_kind_q <= kind_q;
    end
  end

  // kept point table
  msp_store #(
    .Depth (MAX_POINTS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (finish & keep),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (cand_q),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (kept_rd)
  );

  // single distance unit for all kept entries
  assign dist_ctl.clear = accept;
  assign dist_ctl.issue = issue;

  msp_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dist_ctl),
    .kept_i (kept_rd),
    .cand_i (cand_q),
    .sep2_i (sep2_q),
    .sts_o  (dist_sts)
  );

  assign busy       = (fsm_q != msp_pkg::StIdle);
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign slot_o     = slot_q;
  assign out_x_o    = out_pt_q.x;
  assign out_y_o    = out_pt_q.y;
  assign out_z_o    = out_pt_q.z;
  assign out_kind_o = out_kind_q;

  // checks
  `MSP_ASSERT(a_done_after_finish, done_o |-> $past(fsm_q == msp_pkg::StFinish), "result without finish")
  `MSP_ASSERT_NEVER(a_cnt_bound, cnt_q > CntW'(MAX_POINTS), "kept count beyond table")
  `MSP_ASSERT(a_finish_drained, finish |-> !dist_sts.busy, "decision with pipeline busy")
  `MSP_ASSERT(a_issue_in_range, issue |-> (idx_q < cnt_q), "read beyond kept count")
  `MSP_ASSERT(a_accept_busy, accept |=> busy, "item taken but not busy")

endmodule

// ===== sim/min_separation_point_filter_unit_tb.sv =====
`timescale 1ns / 1ps

module min_separation_point_filter_unit_tb;

  import msp_pkg::*;

  localparam int unsigned TablePoints = 16;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 40;

  // one result as seen on the output ports
  typedef struct {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
    logic [CoordW-1:0]  x;
    logic [CoordW-1:0]  y;
    logic [CoordW-1:0]  z;
    logic [KindW-1:0]   kind;
  } filter_res_t;

  // one row of the directed table
  typedef struct {
    logic               new_set;
    logic [CoordW-1:0]  x;
    logic [CoordW-1:0]  y;
    logic [CoordW-1:0]  z;
    logic [KindW-1:0]   kind;
    bit                 typed;
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
  } point_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [SepW-1:0] cfg_wdata_i = '0;
  logic start = 1'b0;
  logic busy;
  logic start_new_set_i = 1'b0;
  logic signed [CoordW-1:0] pos_x_i = '0;
  logic signed [CoordW-1:0] pos_y_i = '0;
  logic signed [CoordW-1:0] pos_z_i = '0;
  logic [KindW-1:0] seed_kind_i = '0;
  logic done_o;
  logic [StatusW-1:0] status_o;
  logic [SlotW-1:0] slot_o;
  logic signed [CoordW-1:0] out_x_o;
  logic signed [CoordW-1:0] out_y_o;
  logic signed [CoordW-1:0] out_z_o;
  logic [KindW-1:0] out_kind_o;

  // model of the kept table
  logic signed [CoordW-1:0] kept_tab_x [TablePoints];
  logic signed [CoordW-1:0] kept_tab_y [TablePoints];
  logic signed [CoordW-1:0] kept_tab_z [TablePoints];
  int unsigned kept_num = 0;
  logic [SepW-1:0] sep_now = SepReset;

  filter_res_t pending_res [$];
  point_row_t  point_rows [$];

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned num_kept = 0;
  int unsigned num_close = 0;
  int unsigned num_full = 0;
  int unsigned num_seps = 1;
  int unsigned burst_left = 5;

  min_separation_point_filter_unit #(
    .MAX_POINTS(TablePoints)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .start_new_set_i(start_new_set_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .seed_kind_i    (seed_kind_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .out_z_o        (out_z_o),
    .out_kind_o     (out_kind_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("ERROR: run limit of %0d cycles reached", CycleLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_error(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s got %0h want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic longint unsigned axis_sq(input logic signed [CoordW-1:0] a,
                                              input logic signed [CoordW-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return longint'(d * d);
  endfunction

  // greedy separation filter: status, slot and echo for one point
  function automatic filter_res_t filter_point(input logic ns, input logic [CoordW-1:0] x,
                                               input logic [CoordW-1:0] y,
                                               input logic [CoordW-1:0] z,
                                               input logic [KindW-1:0] kind);
    filter_res_t r;
    longint unsigned sep2;
    longint unsigned d2;
    bit close;
    close = 1'b0;
    sep2 = longint'(sep_now) * longint'(sep_now);
    if (ns) kept_num = 0;
    for (int i = 0; i < kept_num; i++) begin
      d2 = axis_sq(kept_tab_x[i], x) + axis_sq(kept_tab_y[i], y) + axis_sq(kept_tab_z[i], z);
      if (d2 < sep2) close = 1'b1;
    end
    r.slot = '0;
    if (close) begin
      r.status = StatusClose;
    end else if (kept_num >= TablePoints) begin
      r.status = StatusFull;
    end else begin
      r.status = StatusKept;
      kept_tab_x[kept_num] = x;
      kept_tab_y[kept_num] = y;
      kept_tab_z[kept_num] = z;
      r.slot = kept_num[SlotW-1:0];
      kept_num++;
    end
    r.x = x;
    r.y = y;
    r.z = z;
    r.kind = kind;
    return r;
  endfunction

  // present one point and hold it until taken
  task automatic send_point(input point_row_t row);
    filter_res_t r;
    start_new_set_i <= row.new_set;
    pos_x_i <= row.x;
    pos_y_i <= row.y;
    pos_z_i <= row.z;
    seed_kind_i <= row.kind;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    r = filter_point(row.new_set, row.x, row.y, row.z, row.kind);
    if (row.typed) begin
      r.status = row.status;
      r.slot = row.slot;
    end
    case (r.status)
      StatusKept:  num_kept++;
      StatusClose: num_close++;
      default:     num_full++;
    endcase
    pending_res.insert(pending_res.size(), r);
    items_sent++;
  endtask

  task automatic pause_sender(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // hold off until every result is back
  task automatic wait_all_done();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_sep(input logic [SepW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sep_now = v;
    num_seps++;
  endtask

  // bursts with random gaps, now and then a long unbroken run
  task automatic pace_sender();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      pause_sender($urandom_range(1, 30));
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
    end
    if ($urandom_range(0, 149) == 0) wait_all_done();
  endtask

  function automatic point_row_t mk_row(input logic ns, input logic [CoordW-1:0] x,
                                        input logic [CoordW-1:0] y,
                                        input logic [CoordW-1:0] z,
                                        input logic [KindW-1:0] kind, input bit typed,
                                        input logic [StatusW-1:0] st,
                                        input logic [SlotW-1:0] sl);
    point_row_t row;
    row.new_set = ns;
    row.x = x;
    row.y = y;
    row.z = z;
    row.kind = kind;
    row.typed = typed;
    row.status = st;
    row.slot = sl;
    return row;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input point_row_t row);
    point_rows.insert(point_rows.size(), row);
  endfunction

  function automatic logic [CoordW-1:0] near_coord(input logic [CoordW-1:0] c,
                                                   input int unsigned spread);
    int off;
    off = int'($urandom_range(0, 2 * spread)) - int'(spread);
    return c + off[CoordW-1:0];
  endfunction

  // result checker, one strobe per item
  always @(posedge clk_i) begin
    filter_res_t want;
    if (rst_ni && done_o) begin
      if (pending_res.size() == 0) begin
        report_error("result with nothing pending, status", status_o, 0);
      end else begin
        want = pending_res.pop_front();
        if (status_o !== want.status) report_error("status", status_o, want.status);
        if (slot_o !== want.slot) report_error("slot", slot_o, want.slot);
        if (out_x_o !== want.x) report_error("out_x", out_x_o, want.x);
        if (out_y_o !== want.y) report_error("out_y", out_y_o, want.y);
        if (out_z_o !== want.z) report_error("out_z", out_z_o, want.z);
        if (out_kind_o !== want.kind) report_error("out_kind", out_kind_o, want.kind);
      end
    end
  end

  initial begin
    logic [SepW-1:0] sep_plan [8];
    logic [CoordW-1:0] cx, cy, cz;
    point_row_t row;
    int unsigned set_len;
    int unsigned spread;
    int unsigned phase_items;

    // directed: reset separation of 3 units, boundary distance, extremes
    add_row(mk_row(1'b0, 16'h0000, 16'h0000, 16'h0000, 2'd0, 1, StatusKept, 4'd0));
    add_row(mk_row(1'b0, 16'h0000, 16'h0000, 16'd47, 2'd1, 1, StatusClose, 4'd0));
    add_row(mk_row(1'b0, 16'h0000, 16'h0000, 16'd48, 2'd2, 1, StatusKept, 4'd1));
    add_row(mk_row(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 2'd1, 1, StatusKept, 4'd2));
    add_row(mk_row(1'b0, 16'h8000, 16'h8000, 16'h8000, 2'd2, 1, StatusKept, 4'd3));
    // unused seed kind is only echoed
    add_row(mk_row(1'b0, 16'h7FFF, 16'h8000, 16'h0000, 2'd3, 1, StatusKept, 4'd4));
    // new set empties the table, then fill it
    add_row(mk_row(1'b1, 16'h0000, 16'h0000, 16'h0000, 2'd3, 1, StatusKept, 4'd0));
    for (int i = 1; i < TablePoints; i++) begin
      add_row(mk_row(1'b0, 16'(i * 100), 16'h0000, 16'h0000, 2'(i), 0,
                     StatusKept, 4'd0));
    end
    // full table, then too close and full where too close wins
    add_row(mk_row(1'b0, -16'sd5000, 16'h0000, 16'h0000, 2'd0, 1, StatusFull, 4'd0));
    add_row(mk_row(1'b0, 16'd1, 16'd1, 16'd1, 2'd1, 1, StatusClose, 4'd0));

    // hold reset, then release it
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (point_rows[i]) begin
      send_point(point_rows[i]);
      pace_sender();
    end
    wait_all_done();

    // random phases, each under its own separation
    sep_plan[0] = 12'd0;
    sep_plan[1] = 12'd4095;
    sep_plan[2] = 12'd1;
    sep_plan[3] = 12'($urandom_range(2, 200));
    sep_plan[4] = 12'($urandom_range(200, 4094));
    sep_plan[5] = 12'd0;
    sep_plan[6] = 12'($urandom_range(1, 4095));
    sep_plan[7] = 12'd4095;

    foreach (sep_plan[p]) begin
      write_sep(sep_plan[p]);
      phase_items = 0;
      while (phase_items < 200) begin
        if ($urandom_range(0, 99) < 15) begin
          // noise: any field value, set flag at random
          row = mk_row(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       2'($urandom), 0, StatusKept, 4'd0);
          send_point(row);
          pace_sender();
          phase_items++;
        end else begin
          // a set of points around one centre, long enough to fill at times
          cx = 16'($urandom);
          cy = 16'($urandom);
          cz = 16'($urandom);
          set_len = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 24)
                                                 : $urandom_range(1, 12);
          spread = 2 * sep_now + 8;
          for (int k = 0; k < set_len; k++) begin
            row = mk_row(k == 0, near_coord(cx, spread), near_coord(cy, spread),
                         near_coord(cz, spread), 2'($urandom), 0, StatusKept, 4'd0);
            send_point(row);
            pace_sender();
            phase_items++;
          end
        end
      end
      wait_all_done();
    end

    // settle, then look for stray results
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d points under %0d separation settings", items_sent, num_seps);
    $display("outcomes: %0d kept, %0d too close, %0d table full", num_kept, num_close,
             num_full);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== min_separation_point_filter_unit.f =====
+incdir+rtl
rtl/msp_pkg.sv
rtl/msp_store.sv
rtl/msp_dist.sv
rtl/min_separation_point_filter_unit.sv
sim/min_separation_point_filter_unit_tb.sv
